/* hdl/dbcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_pkg
// Shared types and constants for the depth-bucket counting sort.
// ----------------------------------------------------------------------------
package dbcs_pkg;

    localparam int NUM_BUCKETS_DEF = 16384;
    localparam int MAX_POINTS_DEF  = 65536;
    localparam int QDEPTH          = 4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_REQ  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam logic [1:0] CFG_EYE_X = 2'd0;
    localparam logic [1:0] CFG_EYE_Y = 2'd1;
    localparam logic [1:0] CFG_EYE_Z = 2'd2;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_DINIT,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_LD_WR,
        B_PF_RD,
        B_PF_WR,
        B_SC_RDK,
        B_SC_RDB,
        B_SC_WR,
        B_RD,
        B_RESP,
        B_EMPTY
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

/* hdl/depth_bucket_counting_sort.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_bucket_counting_sort
// Loads points, buckets them by quantised inverse eye distance and reads the
// load indices back in stable far-to-near order.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) passes through the key unit in order: saturated
// differences, the shared squarer and sum over the three axes, the divisor,
// one restoring-division step per key bit, and a push; a point at or beyond
// the key range skips the division. The back end stores a load by a count
// read and a count write. A request beat (tuser 1) passes in the back end
// through the order memory's registered read; the first request of a batch
// first walks the histogram (a read and a write per bucket) and scatters the
// points (key read, bucket read, write for each). After reset and after the
// final index of a batch the histogram is cleared, during which no beat is
// taken. Configuration writes are always taken.
module depth_bucket_counting_sort
    import dbcs_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int MAX_POINTS  = MAX_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x, pos_y, pos_z
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // point_index
    output logic        m_axis_tlast,   // last_index
    output logic        m_axis_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int KW = $clog2(NUM_BUCKETS);

    logic [31:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic        push, pop, clearing;
    logic [KW:0] push_data, head;
    qstat_t      qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg <= '0;
            eye_y_reg <= '0;
            eye_z_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EYE_X: eye_x_reg <= cfg_data;
                CFG_EYE_Y: eye_y_reg <= cfg_data;
                CFG_EYE_Z: eye_z_reg <= cfg_data;
                default:   eye_x_reg <= eye_x_reg;
            endcase
        end
    end

    dbcs_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (s_axis_tuser),
        .pos_x     (s_axis_tdata[31:0]),
        .pos_y     (s_axis_tdata[63:32]),
        .pos_z     (s_axis_tdata[95:64]),
        .eye_x     (eye_x_reg),
        .eye_y     (eye_y_reg),
        .eye_z     (eye_z_reg),
        .hold      (clearing),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    dbcs_queue #(.EW(KW + 1)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    dbcs_back #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_POINTS(MAX_POINTS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head),
        .qstat       (qstat),
        .pop         (pop),
        .clearing    (clearing),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .point_index (m_axis_tdata),
        .last_index  (m_axis_tlast),
        .status      (m_axis_tuser)
    );

endmodule

/* hdl/dbcs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_queue
// Short command queue between the key front end and the sort back end.
// ----------------------------------------------------------------------------
module dbcs_queue
    import dbcs_pkg::*;
#(
    parameter int EW = 15
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [EW-1:0] push_data,
    input  logic          pop,
    output logic [EW-1:0] head,
    output qstat_t        stat
);

    localparam int AW = $clog2(QDEPTH);

    logic [EW-1:0] mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          do_push, do_pop;

    assign stat.full  = (cnt_reg == (AW+1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/dbcs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_front
// Takes input beats, forms the squared eye distance and the bucket key by
// restoring division, and queues load or request commands.
// ----------------------------------------------------------------------------
module dbcs_front
    import dbcs_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [31:0]                  pos_x,
    input  logic [31:0]                  pos_y,
    input  logic [31:0]                  pos_z,
    input  logic [31:0]                  eye_x,
    input  logic [31:0]                  eye_y,
    input  logic [31:0]                  eye_z,
    input  logic                         hold,
    input  qstat_t                       qstat,
    output logic                         push,
    output logic [$clog2(NUM_BUCKETS):0] push_data
);

    localparam int KW   = $clog2(NUM_BUCKETS);
    localparam int NUMW = $clog2(10 * NUM_BUCKETS) + 32;
    localparam int DENW = $clog2(10 * (NUM_BUCKETS + 1)) + 32;
    localparam int SW   = DENW + KW;
    localparam int SCW  = $clog2(KW) + 1;
    localparam int TENN = 10 * NUM_BUCKETS - 1;
    localparam logic [SW-1:0] NUM_C = SW'(NUMW'(TENN) << 32);

    front_state_t  state_reg, state_next;
    logic [30:0]   mag_reg [3];
    logic [30:0]   mag_next [3];
    logic [1:0]    sq_reg, sq_next;
    logic [61:0]   prod_reg, prod_next;
    logic [63:0]   acc_reg, acc_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dsh_reg, dsh_next;
    logic [KW-1:0] q_reg, q_next;
    logic [SCW-1:0] stp_reg, stp_next;
    logic          accept;
    logic          far;
    logic [67:0]   dplus;
    logic          ge;
    logic [KW-1:0] q_step;

    function automatic logic [30:0] sat_abs(input logic [31:0] p, input logic [31:0] e);
        logic signed [32:0] d;
        logic        [32:0] m;
        d = $signed({p[31], p}) - $signed({e[31], e});
        m = d[32] ? 33'(-d) : 33'(d);
        if (m > 33'h07FFFFFFF)
        begin
            return 31'h7FFFFFFF;
        end
        return m[30:0];
    endfunction

    assign in_ready = (state_reg == F_IDLE) && !qstat.full && !hold;
    assign accept   = in_valid && in_ready;
    assign far      = (acc_reg[63:32] >= 32'(NUM_BUCKETS));
    assign dplus    = 68'(acc_reg) + (68'd1 << 32);
    assign ge       = (rem_reg >= dsh_reg);
    assign q_step   = {q_reg[KW-2:0], ge};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept && mode == MODE_LOAD) state_next = F_SQ;
            F_SQ:    if (sq_reg == 2'd3) state_next = F_DINIT;
            F_DINIT: state_next = far ? F_PUSH : F_DIV;
            F_DIV:   if (stp_reg == '0) state_next = F_PUSH;
            F_PUSH:  if (!qstat.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        mag_next  = mag_reg;
        sq_next   = sq_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        stp_next  = stp_reg;
        push      = 1'b0;
        push_data = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    mag_next[0] = sat_abs(pos_x, eye_x);
                    mag_next[1] = sat_abs(pos_y, eye_y);
                    mag_next[2] = sat_abs(pos_z, eye_z);
                    sq_next     = '0;
                    acc_next    = '0;
                    if (mode == MODE_REQ)
                    begin
                        push      = 1'b1;
                        push_data = {1'b1, KW'(0)};
                    end
                end
            end
            F_SQ:
            begin
                // product of the previous cycle is summed while the next one forms
                if (sq_reg != 2'd3)
                begin
                    prod_next = mag_reg[sq_reg] * mag_reg[sq_reg];
                end
                if (sq_reg != 2'd0)
                begin
                    acc_next = acc_reg + 64'(prod_reg);
                end
                sq_next = sq_reg + 1'b1;
            end
            F_DINIT:
            begin
                q_next   = '0;
                rem_next = NUM_C;
                dsh_next = SW'(DENW'((dplus << 3) + (dplus << 1))) << (KW - 1);
                stp_next = SCW'(KW - 1);
            end
            F_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next = dsh_reg >> 1;
                q_next   = q_step;
                stp_next = stp_reg - 1'b1;
            end
            F_PUSH:
            begin
                push = 1'b1;
                if (q_reg > KW'(NUM_BUCKETS - 1))
                begin
                    push_data = {1'b0, KW'(NUM_BUCKETS - 1)};
                end
                else
                begin
                    push_data = {1'b0, q_reg};
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= (state_reg == F_DINIT && far) ? '0 : q_next;
        stp_reg  <= stp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sq_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sq_reg    <= sq_next;
        end
    end

endmodule

/* hdl/dbcs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_back
// Key store, histogram, prefix and scatter walk, readout and output register.
// ----------------------------------------------------------------------------
module dbcs_back
    import dbcs_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int MAX_POINTS  = MAX_POINTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(NUM_BUCKETS):0] cmd,
    input  qstat_t                       qstat,
    output logic                         pop,
    output logic                         clearing,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [15:0]                  point_index,
    output logic                         last_index,
    output logic                         status
);

    localparam int KW = $clog2(NUM_BUCKETS);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] cnt_mem [NUM_BUCKETS];
    logic [PW-1:0] ord_mem [MAX_POINTS];
    logic [KW-1:0] pkey_mem [MAX_POINTS];

    back_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic [CW-1:0] run_reg, run_next;
    logic [PW-1:0] scan_reg, scan_next;
    logic [KW-1:0] bidx_reg, bidx_next;
    logic [KW-1:0] key_reg, key_next;
    logic          done_reg, done_next;
    logic          ov_reg, ov_next;
    logic [15:0]   oidx_reg, oidx_next;
    logic          olast_reg, olast_next;
    logic          ostat_reg, ostat_next;

    logic          k_we;
    logic [PW-1:0] k_ra;
    logic [KW-1:0] k_rd;
    logic          c_we;
    logic [KW-1:0] c_wa, c_ra;
    logic [CW-1:0] c_wd, c_rd;
    logic          s_we;
    logic [PW-1:0] s_wa, s_ra, s_rd;
    logic          out_free;
    logic          is_req;
    logic          rp_last;

    assign out_free    = !ov_reg || out_ready;
    assign is_req      = cmd[KW];
    assign rp_last     = (CW'(rp_reg + 1'b1) == count_reg);
    assign clearing    = (state_reg == B_CLEAR);
    assign out_valid   = ov_reg;
    assign point_index = oidx_reg;
    assign last_index  = olast_reg;
    assign status      = ostat_reg;

    // unused header array kept out: bucket starts reuse the count memory in place
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            pkey_mem[count_reg[PW-1:0]] <= cmd[KW-1:0];
        end
        k_rd <= pkey_mem[k_ra];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cnt_mem[c_wa] <= c_wd;
        end
        c_rd <= cnt_mem[c_ra];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            ord_mem[s_wa] <= scan_reg;
        end
        s_rd <= ord_mem[s_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:  if (bidx_reg == KW'(NUM_BUCKETS - 1)) state_next = B_IDLE;
            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (is_req)
                    begin
                        if (count_reg == '0)
                            state_next = B_EMPTY;
                        else if (!done_reg)
                            state_next = B_PF_RD;
                        else
                            state_next = B_RD;
                    end
                    else if (!done_reg && count_reg != CW'(MAX_POINTS))
                    begin
                        state_next = B_LD_WR;
                    end
                end
            end
            B_LD_WR:  state_next = B_IDLE;
            B_PF_RD:  state_next = B_PF_WR;
            B_PF_WR:  if (bidx_reg == KW'(NUM_BUCKETS - 1)) state_next = B_SC_RDK;
                      else state_next = B_PF_RD;
            B_SC_RDK: state_next = B_SC_RDB;
            B_SC_RDB: state_next = B_SC_WR;
            B_SC_WR:  if (CW'(scan_reg) == CW'(count_reg - 1'b1)) state_next = B_RD;
                      else state_next = B_SC_RDK;
            B_RD:     state_next = B_RESP;
            B_RESP:   if (out_free) state_next = rp_last ? B_CLEAR : B_IDLE;
            B_EMPTY:  if (out_free) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        rp_next    = rp_reg;
        run_next   = run_reg;
        scan_next  = scan_reg;
        bidx_next  = bidx_reg;
        key_next   = key_reg;
        done_next  = done_reg;
        ov_next    = ov_reg && !out_ready;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        ostat_next = ostat_reg;
        pop        = 1'b0;
        k_we       = 1'b0;
        k_ra       = scan_reg;
        c_we       = 1'b0;
        c_wa       = bidx_reg;
        c_wd       = '0;
        c_ra       = bidx_reg;
        s_we       = 1'b0;
        s_wa       = c_rd[PW-1:0];
        s_ra       = rp_reg[PW-1:0];
        case (state_reg)
            B_CLEAR:
            begin
                c_we      = 1'b1;
                bidx_next = bidx_reg + 1'b1;
            end
            B_IDLE:
            begin
                pop = !qstat.empty;
                if (!qstat.empty && !is_req && !done_reg && count_reg != CW'(MAX_POINTS))
                begin
                    k_we     = 1'b1;
                    c_ra     = cmd[KW-1:0];
                    key_next = cmd[KW-1:0];
                end
                bidx_next = '0;
                run_next  = '0;
            end
            B_LD_WR:
            begin
                c_we       = 1'b1;
                c_wa       = key_reg;
                c_wd       = CW'(c_rd + 1'b1);
                count_next = count_reg + 1'b1;
            end
            B_PF_WR:
            begin
                c_we      = 1'b1;
                c_wd      = run_reg;
                run_next  = CW'(run_reg + c_rd);
                bidx_next = bidx_reg + 1'b1;
                scan_next = '0;
            end
            B_SC_RDB:
            begin
                c_ra     = k_rd;
                key_next = k_rd;
            end
            B_SC_WR:
            begin
                s_we      = 1'b1;
                c_we      = 1'b1;
                c_wa      = key_reg;
                c_wd      = CW'(c_rd + 1'b1);
                scan_next = scan_reg + 1'b1;
                if (CW'(scan_reg) == CW'(count_reg - 1'b1))
                begin
                    done_next = 1'b1;
                    rp_next   = '0;
                end
            end
            B_RESP:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = 16'(s_rd);
                    olast_next = rp_last;
                    ostat_next = STATUS_OK;
                    rp_next    = rp_reg + 1'b1;
                    if (rp_last)
                    begin
                        count_next = '0;
                        rp_next    = '0;
                        done_next  = 1'b0;
                        bidx_next  = '0;
                    end
                end
            end
            B_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = '0;
                    olast_next = 1'b0;
                    ostat_next = STATUS_EMPTY;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        run_reg   <= run_next;
        scan_reg  <= scan_next;
        key_reg   <= key_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
        ostat_reg <= ostat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            count_reg <= '0;
            rp_reg    <= '0;
            bidx_reg  <= '0;
            done_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rp_reg    <= rp_next;
            bidx_reg  <= bidx_next;
            done_reg  <= done_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> count_reg != '0)
        else $error("sorted with no points");

    a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rp_reg < count_reg)
        else $error("read pointer past point count");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RESP && out_free && rp_last) |=> state_reg == B_CLEAR && !done_reg)
        else $error("final beat did not start the clear");
`endif

endmodule

/* dv/depth_bucket_counting_sort_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_bucket_counting_sort_tb
// Self-checking bench for the depth-bucket counting sort. Points are loaded
// over the input stream, the eye is moved between batches over the
// configuration channel, and every returned index is checked in order
// against a local model of the keying and the stable bucket sort. Both
// stream sides are throttled at random, except during one calm batch.
// ----------------------------------------------------------------------------
module depth_bucket_counting_sort_tb;
    import dbcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int MAX_PTS        = MAX_POINTS_DEF;
    localparam int TOP_KEY        = NUM_BUCKETS_DEF - 1;

    typedef struct {
        logic [15:0] point_index;
        logic        last_index;
        logic        status;
    } sort_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // local copy of the block's state
    longint      eye_pos [3];
    int          batch_keys[$];
    int          batch_order[$];
    int          read_ptr;
    bit          sorted;

    sort_beat_t  pending_indices[$];
    int          errors;
    int          n_loads;
    int          n_reqs;
    int          n_checked;
    int          n_batches;
    int          idle_cycles;
    bit          calm;

    depth_bucket_counting_sort u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned diff_squared(logic [31:0] p, longint e);
        longint d;
        d = longint'($signed(p)) - e;
        if (d > 64'sd2147483647)
            d = 64'sd2147483647;
        if (d < -64'sd2147483647)
            d = -64'sd2147483647;
        if (d < 0)
            d = -d;
        return longint'(d) * longint'(d);
    endfunction

    function automatic int depth_key(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        longint unsigned dd;
        longint unsigned num;
        longint unsigned den;
        longint unsigned k;
        dd = diff_squared(px, eye_pos[0]) + diff_squared(py, eye_pos[1])
           + diff_squared(pz, eye_pos[2]);
        if (dd >= (longint'(NUM_BUCKETS_DEF) << 32))
            return 0;
        num = (longint'(NUM_BUCKETS_DEF) * 10 - 1) << 32;
        den = 10 * (dd + (64'd1 << 32));
        k = num / den;
        if (k > TOP_KEY)
            k = TOP_KEY;
        return int'(k);
    endfunction

    // stable rank: smaller keys first, load order among equal keys
    task automatic build_order();
        int n;
        int rank;
        n = batch_keys.size();
        batch_order.delete();
        for (int i = 0; i < n; i++)
            batch_order.insert(i, 0);
        for (int i = 0; i < n; i++)
        begin
            rank = 0;
            for (int j = 0; j < n; j++)
                if (batch_keys[j] < batch_keys[i] || (batch_keys[j] == batch_keys[i] && j < i))
                    rank++;
            batch_order[rank] = i;
        end
        sorted = 1'b1;
        read_ptr = 0;
    endtask

    task automatic predict_beat(logic mode, logic [95:0] data);
        sort_beat_t r;
        if (mode == MODE_LOAD)
        begin
            if (!sorted && batch_keys.size() < MAX_PTS)
                batch_keys.insert(batch_keys.size(),
                                  depth_key(data[31:0], data[63:32], data[95:64]));
            return;
        end
        if (batch_keys.size() == 0)
        begin
            r.point_index = '0;
            r.last_index = 1'b0;
            r.status = STATUS_EMPTY;
        end
        else
        begin
            if (!sorted)
                build_order();
            r.point_index = batch_order[read_ptr][15:0];
            r.status = STATUS_OK;
            read_ptr++;
            r.last_index = (read_ptr >= batch_keys.size());
            if (r.last_index)
            begin
                batch_keys.delete();
                sorted = 1'b0;
                read_ptr = 0;
            end
        end
        pending_indices.insert(pending_indices.size(), r);
    endtask

    task automatic send_beat(logic mode, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        if (!calm && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {pz, py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_beat(mode, {pz, py, px});
        if (mode == MODE_LOAD)
            n_loads++;
        else
            n_reqs++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_beat(MODE_LOAD, px, py, pz);
    endtask

    task automatic request_index();
        send_beat(MODE_REQ, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_indices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_eye(logic [1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        eye_pos[idx] = longint'($signed(value));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_eye(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        wait_drained();
        write_eye(CFG_EYE_X, ex);
        write_eye(CFG_EYE_Y, ey);
        write_eye(CFG_EYE_Z, ez);
    endtask

    task automatic read_out_batch();
        int n;
        n = batch_keys.size();
        for (int i = 0; i < n; i++)
            request_index();
        n_batches++;
    endtask

    // mostly near the eye so that keys spread over the whole range
    function automatic logic [31:0] near_coord(int axis);
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return $urandom;
        if (sel < 12)
            return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (sel < 20)
            return eye_pos[axis][31:0] + $urandom_range(0, 32'h200) - 32'h100;
        return eye_pos[axis][31:0] + $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    endfunction

    task automatic test_empty_request();
        request_index();
        request_index();
        wait_drained();
    endtask

    task automatic test_extreme_points();
        load_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        load_point(32'h0, 32'h0, 32'h0);
        load_point(32'h1, 32'h0, 32'hFFFF_FFFF);
        load_point(32'h0001_0000, 32'h0, 32'h0);
        load_point(32'h0000_8000, 32'hFFFF_8000, 32'h0);
        load_point(32'h0, 32'h0, 32'h0);
        load_point(32'h0040_0000, 32'h0, 32'h0);
        read_out_batch();
    endtask

    task automatic test_single_point();
        load_point(32'h0002_0000, 32'h0, 32'h0);
        read_out_batch();
        request_index();
    endtask

    task automatic test_load_during_readout();
        load_point(32'h0, 32'h0003_0000, 32'h0);
        load_point(32'h0, 32'h0, 32'h0);
        load_point(32'h0003_0000, 32'h0, 32'h0);
        request_index();
        // ignored while the batch is being read out
        load_point(32'h0, 32'h0, 32'h0);
        load_point(32'h0001_0000, 32'h0, 32'h0);
        request_index();
        request_index();
        request_index();
        n_batches++;
    endtask

    task automatic test_eye_extremes();
        set_eye(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        load_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        load_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        load_point(32'h7FFF_0000, 32'h8000_FFFF, 32'h7FFF_8000);
        read_out_batch();
        set_eye(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        load_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8001_0000);
        load_point(32'h0, 32'h0, 32'h0);
        read_out_batch();
    endtask

    task automatic test_random_batches();
        int n;
        for (int b = 0; b < 8; b++)
        begin
            calm = (b == 3);
            if ($urandom_range(3) == 0)
                set_eye($urandom, $urandom, $urandom);
            else
                set_eye($urandom_range(0, 32'h40_0000) - 32'h20_0000,
                        $urandom_range(0, 32'h40_0000) - 32'h20_0000,
                        $urandom_range(0, 32'h40_0000) - 32'h20_0000);
            n = $urandom_range(30, 70);
            for (int i = 0; i < n; i++)
                load_point(near_coord(0), near_coord(1), near_coord(2));
            n = batch_keys.size();
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(19) == 0)
                    load_point($urandom, $urandom, $urandom);
                request_index();
            end
            if ($urandom_range(2) == 0)
                request_index();
            n_batches++;
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end

    always @(posedge clk)
    begin
        sort_beat_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_indices.size() == 0)
            begin
                $display("%0t: unexpected result idx=%0d last=%0b status=%0b", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end
            else
            begin
                e = pending_indices.pop_front();
                n_checked++;
                if (m_axis_tdata !== e.point_index || m_axis_tlast !== e.last_index
                    || m_axis_tuser !== e.status)
                begin
                    $display("%0t: mismatch exp idx=%0d last=%0b status=%0b, got idx=%0d last=%0b status=%0b",
                             $time, e.point_index, e.last_index, e.status,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_indices.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        eye_pos[0] = 0;
        eye_pos[1] = 0;
        eye_pos[2] = 0;
        read_ptr = 0;
        sorted = 1'b0;
        errors = 0;
        n_loads = 0;
        n_reqs = 0;
        n_checked = 0;
        n_batches = 0;
        idle_cycles = 0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_request();
        test_extreme_points();
        test_single_point();
        test_load_during_readout();
        test_eye_extremes();
        test_random_batches();
        set_eye(32'h0, 32'h0, 32'h0);

        $display("Covered %0d loads and %0d requests over %0d batches; %0d indices checked.",
                 n_loads, n_reqs, n_batches, n_checked);
        $display("Eye moved through extremes, empty requests and loads during readout included.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
